// ===== sv/assert_macros.svh =====
// Assertion macros shared by the clipper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define SWC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define SWC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/swc_pkg.sv =====
// Types and constants shared by the segment window clipper.
`default_nettype none
package swc_pkg;
  localparam int WIN_W = 12;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_LEFT   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_RIGHT  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BOTTOM = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_TOP    = 2'd3;

  localparam logic [WIN_W-1:0] LEFT_RESET   = 12'd0;
  localparam logic [WIN_W-1:0] RIGHT_RESET  = 12'd639;
  localparam logic [WIN_W-1:0] BOTTOM_RESET = 12'd0;
  localparam logic [WIN_W-1:0] TOP_RESET    = 12'd479;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_PASS  = 2'd1,
    MODE_PULL  = 2'd2,
    MODE_CROSS = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic  swap;
    logic  same_x;
    logic  same_y;
    logic  m_above;
    logic  m_right;
  } ctl_t;

  typedef struct packed {
    logic [WIN_W-1:0] left;
    logic [WIN_W-1:0] right;
    logic [WIN_W-1:0] bottom;
    logic [WIN_W-1:0] top;
  } window_t;
endpackage
`default_nettype wire

// ===== sv/swc_front.sv =====
// Classification, operand preparation and products for the four divider lanes.
`default_nettype none
module swc_front #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS = 8,
  parameter int IW = 25,
  parameter int PW = 50
) (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  swc_pkg::window_t win,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  input  logic first_in_sight,
  input  logic second_in_sight,
  output logic out_valid,
  output swc_pkg::ctl_t ctl,
  output logic signed [COORD_WIDTH-1:0] vx,
  output logic signed [COORD_WIDTH-1:0] vy,
  output logic signed [COORD_WIDTH-1:0] mx,
  output logic signed [COORD_WIDTH-1:0] my,
  output logic [3:0][PW-1:0] prod,
  output logic [3:0][IW-1:0] den,
  output logic [3:0] neg,
  output logic [3:0] zero
);
  import swc_pkg::*;
  localparam int CW = IW - 1;

  function automatic logic [IW-1:0] mag(input logic signed [IW-1:0] v);
    mag = v[IW-1] ? IW'(-v) : IW'(v);
  endfunction

  logic signed [CW-1:0] e_l, e_r, e_b, e_t, p0, p1, p2, p3;
  logic ok1, ok2, reject;
  ctl_t ctl_next;
  logic signed [COORD_WIDTH-1:0] vx_next, vy_next, mx_next, my_next;

  logic v1, v2;
  ctl_t ctl1, ctl2;
  logic signed [COORD_WIDTH-1:0] vx1, vy1, mx1, my1, vx2, vy2, mx2, my2;
  logic signed [IW-1:0] la [4];
  logic signed [IW-1:0] lb [4];
  logic signed [IW-1:0] lc [4];
  logic [IW-1:0] ma2 [4];
  logic [IW-1:0] mb2 [4];
  logic [IW-1:0] mc2 [4];
  logic [3:0] neg2, zero2;

  assign e_l = CW'(win.left) << FRAC_BITS;
  assign e_r = CW'(win.right) << FRAC_BITS;
  assign e_b = CW'(win.bottom) << FRAC_BITS;
  assign e_t = CW'(win.top) << FRAC_BITS;
  assign p0 = CW'(first_x);
  assign p1 = CW'(first_y);
  assign p2 = CW'(second_x);
  assign p3 = CW'(second_y);

  always_comb begin
    ok1 = first_in_sight && p0 >= e_l && p0 <= e_r && p1 >= e_b && p1 <= e_t;
    ok2 = second_in_sight && p2 >= e_l && p2 <= e_r && p3 >= e_b && p3 <= e_t;
    reject = (p1 > e_t && p3 > e_t) || (p1 < e_b && p3 < e_b) ||
             (p0 > e_r && p2 > e_r) || (p0 < e_l && p2 < e_l);
    ctl_next = '0;
    ctl_next.mode = MODE_NONE;
    if (ok1 && ok2) begin
      ctl_next.mode = MODE_PASS;
    end else if (ok1) begin
      if (second_in_sight) ctl_next.mode = MODE_PULL;
    end else if (ok2) begin
      if (first_in_sight) begin
        ctl_next.mode = MODE_PULL;
        ctl_next.swap = 1'b1;
      end
    end else if (first_in_sight && second_in_sight && !reject) begin
      ctl_next.mode = MODE_CROSS;
    end
    vx_next = ctl_next.swap ? second_x : first_x;
    vy_next = ctl_next.swap ? second_y : first_y;
    mx_next = ctl_next.swap ? first_x : second_x;
    my_next = ctl_next.swap ? first_y : second_y;
    ctl_next.same_x = mx_next == vx_next;
    ctl_next.same_y = my_next == vy_next;
    ctl_next.m_above = my_next > vy_next;
    ctl_next.m_right = mx_next > vx_next;
  end

  always_comb begin
    la[0] = IW'(my1) - IW'(vy1);
    lb[0] = IW'(e_l) - IW'(vx1);
    lc[0] = IW'(mx1) - IW'(vx1);
    la[1] = la[0];
    lb[1] = IW'(e_r) - IW'(vx1);
    lc[1] = lc[0];
    la[2] = lc[0];
    lb[2] = IW'(e_b) - IW'(vy1);
    lc[2] = la[0];
    la[3] = lc[0];
    lb[3] = IW'(e_t) - IW'(vy1);
    lc[3] = la[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
    if (adv) begin
      ctl1 <= ctl_next;
      vx1 <= vx_next;
      vy1 <= vy_next;
      mx1 <= mx_next;
      my1 <= my_next;
      ctl2 <= ctl1;
      vx2 <= vx1;
      vy2 <= vy1;
      mx2 <= mx1;
      my2 <= my1;
      for (int i = 0; i < 4; i++) begin
        ma2[i] <= mag(la[i]);
        mb2[i] <= mag(lb[i]);
        mc2[i] <= mag(lc[i]);
        neg2[i] <= la[i][IW-1] ^ lb[i][IW-1] ^ lc[i][IW-1];
        zero2[i] <= lc[i] == '0;
      end
      ctl <= ctl2;
      vx <= vx2;
      vy <= vy2;
      mx <= mx2;
      my <= my2;
      for (int i = 0; i < 4; i++) begin
        prod[i] <= PW'(ma2[i]) * PW'(mb2[i]);
        den[i] <= mc2[i];
      end
      neg <= neg2;
      zero <= zero2;
    end
  end
endmodule
`default_nettype wire

// ===== sv/swc_div.sv =====
// Restoring divider, one quotient bit per pipeline stage, with side data.
`default_nettype none
module swc_div #(
  parameter int NW = 50,
  parameter int DW = 25,
  parameter int SW = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic out_valid,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic [DW-1:0] den_out,
  output logic [SW-1:0] side_out
);
  logic [NW-1:0] vld;
  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] num_r [NW];
  logic [NW-1:0] quo_r [NW];
  logic [DW-1:0] den_r [NW];
  logic [SW-1:0] side_r [NW];

  logic [DW-1:0] rem_c [NW];
  logic [NW-1:0] num_c [NW];
  logic [NW-1:0] quo_c [NW];
  logic [DW-1:0] den_c [NW];
  logic [SW-1:0] side_c [NW];
  logic [DW:0] trial [NW];
  logic [NW-1:0] fit;

  always_comb begin
    rem_c[0] = '0;
    num_c[0] = num;
    quo_c[0] = '0;
    den_c[0] = den;
    side_c[0] = side_in;
    for (int k = 1; k < NW; k++) begin
      rem_c[k] = rem_r[k-1];
      num_c[k] = num_r[k-1];
      quo_c[k] = quo_r[k-1];
      den_c[k] = den_r[k-1];
      side_c[k] = side_r[k-1];
    end
    for (int k = 0; k < NW; k++) begin
      trial[k] = {rem_c[k], num_c[k][NW-1]};
      fit[k] = trial[k] >= {1'b0, den_c[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NW-2:0], in_valid};
    end
    if (adv) begin
      for (int k = 0; k < NW; k++) begin
        rem_r[k] <= fit[k] ? DW'(trial[k] - {1'b0, den_c[k]}) : DW'(trial[k]);
        num_r[k] <= num_c[k] << 1;
        quo_r[k] <= {quo_c[k][NW-2:0], fit[k]};
        den_r[k] <= den_c[k];
        side_r[k] <= side_c[k];
      end
    end
  end

  assign out_valid = vld[NW-1];
  assign quo = quo_r[NW-1];
  assign rem = rem_r[NW-1];
  assign den_out = den_r[NW-1];
  assign side_out = side_r[NW-1];
endmodule
`default_nettype wire

// ===== sv/swc_back.sv =====
// Rounding, endpoint offset, edge selection and output saturation.
`default_nettype none
module swc_back #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS = 8,
  parameter int IW = 25,
  parameter int PW = 50
) (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  swc_pkg::window_t win,
  input  logic [3:0][PW-1:0] quo,
  input  logic [3:0][IW-1:0] rem,
  input  logic [3:0][IW-1:0] den,
  input  logic [3:0] neg,
  input  logic [3:0] zero,
  input  swc_pkg::ctl_t ctl,
  input  logic signed [COORD_WIDTH-1:0] vx,
  input  logic signed [COORD_WIDTH-1:0] vy,
  input  logic signed [COORD_WIDTH-1:0] mx,
  input  logic signed [COORD_WIDTH-1:0] my,
  output logic out_valid,
  output logic draw_segment,
  output logic both_were_valid,
  output logic signed [COORD_WIDTH-1:0] out_first_x,
  output logic signed [COORD_WIDTH-1:0] out_first_y,
  output logic signed [COORD_WIDTH-1:0] out_second_x,
  output logic signed [COORD_WIDTH-1:0] out_second_y
);
  import swc_pkg::*;
  localparam int QW = PW + 1;
  localparam int RW = QW + 2;
  localparam int W = COORD_WIDTH;

  function automatic logic signed [W-1:0] pack(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] hi, lo;
    hi = RW'({1'b0, {(W-1){1'b1}}});
    lo = ~hi;
    if (v > hi) pack = hi[W-1:0];
    else if (v < lo) pack = lo[W-1:0];
    else pack = v[W-1:0];
  endfunction

  logic v1, v2;
  ctl_t ctl1, ctl2;
  logic signed [W-1:0] vx1, vy1, mx1, my1, vx2, vy2, mx2, my2;
  logic [QW-1:0] qr [4];
  logic signed [RW-1:0] sq_next [4];
  logic signed [RW-1:0] sq [4];
  logic signed [RW-1:0] r [4];
  logic signed [RW-1:0] e_l, e_r, e_b, e_t;
  logic signed [RW-1:0] px, py, qx, qy, ax, ay, bx, by, ypull, nx, cx;
  logic signed [RW-1:0] hx [4];
  logic signed [RW-1:0] hy [4];
  logic [3:0] hit;
  logic [1:0] first_i, last_i;
  logic draw_next, both_next;

  assign e_l = RW'(win.left) << FRAC_BITS;
  assign e_r = RW'(win.right) << FRAC_BITS;
  assign e_b = RW'(win.bottom) << FRAC_BITS;
  assign e_t = RW'(win.top) << FRAC_BITS;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qr[i] = QW'(quo[i]) + QW'({rem[i], 1'b0} >= {1'b0, den[i]});
      if (QW > 62) begin
        if (qr[i] > (QW'(1) << 62)) qr[i] = QW'(1) << 62;
      end
      if (zero[i]) sq_next[i] = '0;
      else if (neg[i]) sq_next[i] = -RW'(qr[i]);
      else sq_next[i] = RW'(qr[i]);
    end
  end

  always_comb begin
    px = RW'(vx2);
    py = RW'(vy2);
    qx = RW'(mx2);
    qy = RW'(my2);
    ax = '0;
    ay = '0;
    bx = '0;
    by = '0;
    draw_next = 1'b0;
    both_next = 1'b0;
    ypull = ctl2.same_y ? py : (ctl2.m_above ? e_t : e_b);
    nx = ctl2.m_above ? r[3] : r[2];
    cx = (qx < e_l) ? e_l : qx;
    cx = (cx > e_r) ? e_r : cx;
    hx[0] = e_l;
    hy[0] = r[0];
    hx[1] = e_r;
    hy[1] = r[1];
    hx[2] = r[2];
    hy[2] = e_b;
    hx[3] = r[3];
    hy[3] = e_t;
    hit[0] = r[0] >= e_b && r[0] <= e_t;
    hit[1] = r[1] >= e_b && r[1] <= e_t;
    hit[2] = r[2] >= e_l && r[2] <= e_r;
    hit[3] = r[3] >= e_l && r[3] <= e_r;
    first_i = 2'd0;
    last_i = 2'd0;
    for (int i = 3; i >= 0; i--) if (hit[i]) first_i = 2'(i);
    for (int i = 0; i < 4; i++) if (hit[i]) last_i = 2'(i);
    case (ctl2.mode)
      MODE_PASS: begin
        draw_next = 1'b1;
        both_next = 1'b1;
        ax = ctl2.swap ? qx : px;
        ay = ctl2.swap ? qy : py;
        bx = ctl2.swap ? px : qx;
        by = ctl2.swap ? py : qy;
      end
      MODE_PULL: begin
        draw_next = 1'b1;
        if (ctl2.same_x) begin
          bx = qx;
          by = ypull;
        end else if (ctl2.same_y) begin
          bx = cx;
          by = qy;
        end else if (nx < e_l) begin
          bx = e_l;
          by = r[0];
        end else if (nx > e_r) begin
          bx = e_r;
          by = r[1];
        end else begin
          bx = nx;
          by = ypull;
        end
        ax = px;
        ay = py;
        if (ctl2.swap) begin
          ax = bx;
          ay = by;
          bx = px;
          by = py;
        end
      end
      MODE_CROSS: begin
        if (ctl2.same_x) begin
          draw_next = 1'b1;
          ax = px;
          bx = qx;
          ay = ctl2.m_above ? e_b : e_t;
          by = ctl2.m_above ? e_t : e_b;
        end else if (ctl2.same_y) begin
          draw_next = 1'b1;
          ay = py;
          by = qy;
          ax = ctl2.m_right ? e_l : e_r;
          bx = ctl2.m_right ? e_r : e_l;
        end else begin
          draw_next = $countones(hit) == 2;
          ax = hx[first_i];
          ay = hy[first_i];
          bx = hx[last_i];
          by = hy[last_i];
        end
        both_next = draw_next;
      end
      default: begin
        draw_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
    if (adv) begin
      for (int i = 0; i < 4; i++) sq[i] <= sq_next[i];
      ctl1 <= ctl;
      vx1 <= vx;
      vy1 <= vy;
      mx1 <= mx;
      my1 <= my;
      r[0] <= sq[0] + RW'(vy1);
      r[1] <= sq[1] + RW'(vy1);
      r[2] <= sq[2] + RW'(vx1);
      r[3] <= sq[3] + RW'(vx1);
      ctl2 <= ctl1;
      vx2 <= vx1;
      vy2 <= vy1;
      mx2 <= mx1;
      my2 <= my1;
      draw_segment <= draw_next;
      both_were_valid <= both_next;
      out_first_x <= draw_next ? pack(ax) : '0;
      out_first_y <= draw_next ? pack(ay) : '0;
      out_second_x <= draw_next ? pack(bx) : '0;
      out_second_y <= draw_next ? pack(by) : '0;
    end
  end
endmodule
`default_nettype wire

// ===== sv/segment_window_clipper_core.sv =====
// Top level of the segment window clipper: ports, window registers, lane wiring.
`default_nettype none
`include "assert_macros.svh"
// Clips one screen segment (two signed Q.FRAC_BITS endpoints with in-sight
// flags) to the configured window and returns one result per request. The
// block is fully pipelined and takes a new request every cycle unless the
// output is stalled. The four divider lanes resolve one quotient bit per stage.
// Write window registers only while no request is in flight.
module segment_window_clipper_core #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // first_x, first_y, second_x, second_y
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  // first_in_sight, second_in_sight
  input  logic [1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // out_first_x, out_first_y, out_second_x, out_second_y
  output logic [((4*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
  // draw_segment, both_were_valid
  output logic [1:0] m_tuser,
  input  logic cfg_en,
  input  logic [swc_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [swc_pkg::WIN_W-1:0] cfg_data
);
  import swc_pkg::*;
  localparam int W = COORD_WIDTH;
  localparam int CWM = (W > WIN_W + 1 + FRAC_BITS) ? W : WIN_W + 1 + FRAC_BITS;
  localparam int IW = CWM + 1;
  localparam int PW = 2 * IW;
  localparam int TW = ((4 * W + 7) / 8) * 8;
  localparam int SIDE_W = $bits(ctl_t) + 4 * W + 2;

  logic adv;
  window_t win;
  logic signed [W-1:0] in_fx, in_fy, in_sx, in_sy;
  logic f_valid;
  ctl_t f_ctl, b_ctl;
  logic signed [W-1:0] f_vx, f_vy, f_mx, f_my, b_vx, b_vy, b_mx, b_my;
  logic [3:0][PW-1:0] f_prod, d_quo;
  logic [3:0][IW-1:0] f_den, d_rem, d_den;
  logic [3:0] f_neg, f_zero, d_valid, b_neg, b_zero;
  logic [SIDE_W-1:0] d_side0;
  logic [3:1][1:0] d_sidex;
  logic o_draw, o_both;
  logic signed [W-1:0] o_fx, o_fy, o_sx, o_sy;

  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign in_fx = s_tdata[W-1:0];
  assign in_fy = s_tdata[2*W-1:W];
  assign in_sx = s_tdata[3*W-1:2*W];
  assign in_sy = s_tdata[4*W-1:3*W];

  always_ff @(posedge clk) begin
    if (rst) begin
      win.left <= LEFT_RESET;
      win.right <= RIGHT_RESET;
      win.bottom <= BOTTOM_RESET;
      win.top <= TOP_RESET;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_LEFT:   win.left <= cfg_data;
        REG_RIGHT:  win.right <= cfg_data;
        REG_BOTTOM: win.bottom <= cfg_data;
        REG_TOP:    win.top <= cfg_data;
        default: ;
      endcase
    end
  end

  swc_front #(
    .COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS), .IW(IW), .PW(PW)
  ) u_front (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(s_tvalid && adv), .win(win),
    .first_x(in_fx), .first_y(in_fy), .second_x(in_sx), .second_y(in_sy),
    .first_in_sight(s_tuser[0]), .second_in_sight(s_tuser[1]),
    .out_valid(f_valid), .ctl(f_ctl), .vx(f_vx), .vy(f_vy), .mx(f_mx), .my(f_my),
    .prod(f_prod), .den(f_den), .neg(f_neg), .zero(f_zero)
  );

  swc_div #(.NW(PW), .DW(IW), .SW(SIDE_W)) u_div0 (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(f_valid),
    .num(f_prod[0]), .den(f_den[0]),
    .side_in({f_ctl, f_vx, f_vy, f_mx, f_my, f_neg[0], f_zero[0]}),
    .out_valid(d_valid[0]), .quo(d_quo[0]), .rem(d_rem[0]), .den_out(d_den[0]),
    .side_out(d_side0)
  );

  for (genvar i = 1; i < 4; i++) begin : g_lane
    swc_div #(.NW(PW), .DW(IW), .SW(2)) u_div (
      .clk(clk), .rst(rst), .adv(adv), .in_valid(f_valid),
      .num(f_prod[i]), .den(f_den[i]), .side_in({f_neg[i], f_zero[i]}),
      .out_valid(d_valid[i]), .quo(d_quo[i]), .rem(d_rem[i]), .den_out(d_den[i]),
      .side_out(d_sidex[i])
    );
  end

  always_comb begin
    b_ctl = ctl_t'(d_side0[SIDE_W-1 -: $bits(ctl_t)]);
    b_vx = d_side0[4*W+1 -: W];
    b_vy = d_side0[3*W+1 -: W];
    b_mx = d_side0[2*W+1 -: W];
    b_my = d_side0[W+1 -: W];
    b_neg[0] = d_side0[1];
    b_zero[0] = d_side0[0];
    for (int i = 1; i < 4; i++) begin
      b_neg[i] = d_sidex[i][1];
      b_zero[i] = d_sidex[i][0];
    end
  end

  swc_back #(
    .COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS), .IW(IW), .PW(PW)
  ) u_back (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(&d_valid), .win(win),
    .quo(d_quo), .rem(d_rem), .den(d_den), .neg(b_neg), .zero(b_zero),
    .ctl(b_ctl), .vx(b_vx), .vy(b_vy), .mx(b_mx), .my(b_my),
    .out_valid(m_tvalid), .draw_segment(o_draw), .both_were_valid(o_both),
    .out_first_x(o_fx), .out_first_y(o_fy), .out_second_x(o_sx), .out_second_y(o_sy)
  );

  assign m_tdata = TW'({o_sy, o_sx, o_fy, o_fx});
  assign m_tuser = {o_both, o_draw};

  `SWC_ASSERT(a_nodraw_zero, m_tvalid && !m_tuser[0] |-> m_tdata == '0, "undrawn result carries coordinates")
  `SWC_ASSERT(a_both_draw, m_tvalid && m_tuser[1] |-> m_tuser[0], "visible result not drawn")
  `SWC_ASSERT_ALWAYS(a_rst_empty, rst |=> !m_tvalid, "result present after reset")
endmodule
`default_nettype wire

// ===== bench/segment_window_clipper_core_tb.sv =====
// Testbench for the segment window clipper: directed and randomized segments checked against a predictor.
`timescale 1ns / 1ps
module segment_window_clipper_core_tb;
  import swc_pkg::*;

  localparam int CW = 24;
  localparam int FB = 8;
  localparam int LATENCY = 56;
  localparam int LIMIT = 600000;
  localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMIN = -(64'sd1 <<< (CW - 1));
  localparam longint QSAT = 64'sd1 <<< 62;

  typedef struct {
    logic signed [CW-1:0] fx, fy, sx, sy;
    logic s1, s2;
  } segment_t;

  typedef struct {
    logic draw, both;
    logic signed [CW-1:0] fx, fy, sx, sy;
  } clip_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [95:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [95:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_en = 0;
  logic [REG_IDX_W-1:0] cfg_index = REG_LEFT;
  logic [WIN_W-1:0] cfg_data = '0;

  segment_window_clipper_core dut (.*);

  always #5 clk = ~clk;

  logic [WIN_W-1:0] win_l = LEFT_RESET, win_r = RIGHT_RESET;
  logic [WIN_W-1:0] win_b = BOTTOM_RESET, win_t = TOP_RESET;
  longint edge_l, edge_r, edge_b, edge_t;
  assign edge_l = longint'(win_l) <<< FB;
  assign edge_r = longint'(win_r) <<< FB;
  assign edge_b = longint'(win_b) <<< FB;
  assign edge_t = longint'(win_t) <<< FB;

  segment_t pending_segments[$];
  clip_t expected_clips[$];
  int errors = 0;
  bit idle_on = 1;
  int cycles = 0;

  function automatic longint scaled_ratio(longint a, longint b, longint c);
    logic [127:0] prod, q, rem, uc;
    bit neg;
    longint r;
    if (c == 0) return 0;
    neg = ((a < 0) != (b < 0)) != (c < 0);
    prod = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
    uc = 128'(c < 0 ? -c : c);
    q = prod / uc;
    rem = prod % uc;
    if (rem >= uc - rem) q = q + 1;
    if (q > 128'(QSAT)) q = 128'(QSAT);
    r = longint'(q[63:0]);
    return neg ? -r : r;
  endfunction

  function automatic bit in_window(longint x, longint y);
    return x >= edge_l && x <= edge_r && y >= edge_b && y <= edge_t;
  endfunction

  function automatic void pull_end(longint vx, longint vy, inout longint mx, inout longint my);
    longint y, dx, dy, nx;
    y = vy;
    if (my < vy) y = edge_b;
    else if (my > vy) y = edge_t;
    if (mx == vx) begin
      my = y;
      return;
    end
    if (my == vy) begin
      if (mx < edge_l) mx = edge_l;
      if (mx > edge_r) mx = edge_r;
      return;
    end
    dx = mx - vx;
    dy = my - vy;
    nx = vx + scaled_ratio(y - vy, dx, dy);
    my = y;
    if (nx < edge_l) begin
      mx = edge_l;
      my = vy + scaled_ratio(dy, edge_l - vx, dx);
    end else if (nx > edge_r) begin
      mx = edge_r;
      my = vy + scaled_ratio(dy, edge_r - vx, dx);
    end else begin
      mx = nx;
    end
  endfunction

  function automatic bit cross_window(inout longint p[4]);
    longint vx, vy, mx, my, dx, dy, hx[4], hy[4];
    int hits;
    bit hit[4];
    vx = p[0]; vy = p[1]; mx = p[2]; my = p[3];
    hits = 0;
    if ((vy > edge_t && my > edge_t) || (vy < edge_b && my < edge_b) ||
        (vx > edge_r && mx > edge_r) || (vx < edge_l && mx < edge_l))
      return 0;
    if (mx == vx) begin
      if (my > vy) begin p[3] = edge_t; p[1] = edge_b; end
      else begin p[1] = edge_t; p[3] = edge_b; end
      return 1;
    end
    if (my == vy) begin
      if (mx > vx) begin p[2] = edge_r; p[0] = edge_l; end
      else begin p[0] = edge_r; p[2] = edge_l; end
      return 1;
    end
    dx = mx - vx;
    dy = my - vy;
    hx[0] = edge_l; hy[0] = vy + scaled_ratio(dy, edge_l - vx, dx);
    hx[1] = edge_r; hy[1] = vy + scaled_ratio(dy, edge_r - vx, dx);
    hx[2] = vx + scaled_ratio(dx, edge_b - vy, dy); hy[2] = edge_b;
    hx[3] = vx + scaled_ratio(dx, edge_t - vy, dy); hy[3] = edge_t;
    hit[0] = hy[0] >= edge_b && hy[0] <= edge_t;
    hit[1] = hy[1] >= edge_b && hy[1] <= edge_t;
    hit[2] = hx[2] >= edge_l && hx[2] <= edge_r;
    hit[3] = hx[3] >= edge_l && hx[3] <= edge_r;
    for (int k = 0; k < 4; k++) begin
      if (hit[k]) begin
        if (hits > 0) begin p[2] = hx[k]; p[3] = hy[k]; end
        else begin p[0] = hx[k]; p[1] = hy[k]; end
        hits++;
      end
    end
    return hits == 2;
  endfunction

  function automatic logic signed [CW-1:0] sat_coord(longint v);
    if (v > CMAX) v = CMAX;
    if (v < CMIN) v = CMIN;
    return v[CW-1:0];
  endfunction

  function automatic clip_t clip_segment(segment_t s);
    longint p[4];
    bit ok1, ok2;
    clip_t c;
    p[0] = s.fx; p[1] = s.fy; p[2] = s.sx; p[3] = s.sy;
    ok1 = s.s1 && in_window(p[0], p[1]);
    ok2 = s.s2 && in_window(p[2], p[3]);
    c.draw = 0;
    c.both = 0;
    if (ok1 && ok2) begin
      c.draw = 1;
      c.both = 1;
    end else if (ok1) begin
      if (s.s2) begin pull_end(p[0], p[1], p[2], p[3]); c.draw = 1; end
    end else if (ok2) begin
      if (s.s1) begin pull_end(p[2], p[3], p[0], p[1]); c.draw = 1; end
    end else if (s.s1 && s.s2) begin
      c.draw = cross_window(p);
      c.both = c.draw;
    end
    c.fx = c.draw ? sat_coord(p[0]) : '0;
    c.fy = c.draw ? sat_coord(p[1]) : '0;
    c.sx = c.draw ? sat_coord(p[2]) : '0;
    c.sy = c.draw ? sat_coord(p[3]) : '0;
    return c;
  endfunction

  segment_t cur_seg;
  int src_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else begin
      if (s_tvalid && s_tready) expected_clips.push_back(clip_segment(cur_seg));
      if (!(s_tvalid && !s_tready)) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 0;
        end else if (pending_segments.size() > 0) begin
          cur_seg = pending_segments.pop_front();
          s_tdata <= {cur_seg.sy, cur_seg.sx, cur_seg.fy, cur_seg.fx};
          s_tuser <= {cur_seg.s2, cur_seg.s1};
          s_tvalid <= 1;
          if (idle_on && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 15);
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  int sink_stall = 0;

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    clip_t e;
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_clips.size() == 0) begin
          $error("unexpected result: tdata %h tuser %b", m_tdata, m_tuser);
          errors++;
        end else begin
          e = expected_clips.pop_front();
          check_field("draw_segment", e.draw, m_tuser[0]);
          check_field("both_were_valid", e.both, m_tuser[1]);
          check_field("out_first_x", e.fx, $signed(m_tdata[23:0]));
          check_field("out_first_y", e.fy, $signed(m_tdata[47:24]));
          check_field("out_second_x", e.sx, $signed(m_tdata[71:48]));
          check_field("out_second_y", e.sy, $signed(m_tdata[95:72]));
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_tready <= 0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        sink_stall = $urandom_range(1, 15) - 1;
        m_tready <= 0;
      end else begin
        m_tready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("segment_window_clipper_core_tb: errors");
      $finish;
    end
  end

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [WIN_W-1:0] val);
    @(posedge clk);
    cfg_en <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_en <= 0;
    case (idx)
      REG_LEFT: win_l = val;
      REG_RIGHT: win_r = val;
      REG_BOTTOM: win_b = val;
      REG_TOP: win_t = val;
      default: ;
    endcase
  endtask

  task automatic set_window(int l, int r, int b, int t);
    write_reg(REG_LEFT, WIN_W'(l));
    write_reg(REG_RIGHT, WIN_W'(r));
    write_reg(REG_BOTTOM, WIN_W'(b));
    write_reg(REG_TOP, WIN_W'(t));
  endtask

  task automatic drain();
    while (pending_segments.size() > 0 || s_tvalid || expected_clips.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] rand_coord(longint a, longint b);
    longint lo, hi, v;
    lo = a < b ? a : b;
    hi = a < b ? b : a;
    case ($urandom_range(0, 9))
      5: v = $urandom_range(0, 1) ? lo : hi;
      6: v = $signed(CW'($urandom));
      7: v = $urandom_range(0, 1) ? CMAX : CMIN;
      8, 9: v = longint'($urandom_range(0, 4095 << FB));
      default: v = lo - (64 << FB) + longint'($urandom_range(0, int'(hi - lo) + (128 << FB)));
    endcase
    return sat_coord(v);
  endfunction

  task automatic add_segment(longint fx, longint fy, longint sx, longint sy, bit s1, bit s2);
    segment_t s;
    s.fx = CW'(fx); s.fy = CW'(fy); s.sx = CW'(sx); s.sy = CW'(sy);
    s.s1 = s1; s.s2 = s2;
    pending_segments.push_back(s);
  endtask

  task automatic add_random(int n);
    segment_t s;
    repeat (n) begin
      s.fx = rand_coord(edge_l, edge_r);
      s.fy = rand_coord(edge_b, edge_t);
      s.sx = rand_coord(edge_l, edge_r);
      s.sy = rand_coord(edge_b, edge_t);
      case ($urandom_range(0, 9))
        0: s.sx = s.fx;
        1: s.sy = s.fy;
        default: ;
      endcase
      s.s1 = $urandom_range(0, 7) != 0;
      s.s2 = $urandom_range(0, 7) != 0;
      pending_segments.push_back(s);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    // directed, reset window 0..639 x 0..479
    add_segment(10 << FB, 20 << FB, 600 << FB, 400 << FB, 1, 1);
    add_segment(0, 0, 639 << FB, 479 << FB, 1, 1);
    add_segment(100 << FB, 100 << FB, 900 << FB, 700 << FB, 1, 1);
    add_segment(-300 << FB, 50 << FB, 100 << FB, 200 << FB, 1, 1);
    add_segment(100 << FB, 100 << FB, 100 << FB, 900 << FB, 1, 1);
    add_segment(100 << FB, 100 << FB, -50 << FB, 100 << FB, 1, 1);
    add_segment(100 << FB, 100 << FB, 900 << FB, 100 << FB, 1, 1);
    add_segment(100 << FB, 100 << FB, 900 << FB, 700 << FB, 1, 0);
    add_segment(900 << FB, 700 << FB, 100 << FB, 100 << FB, 0, 1);
    add_segment(-100 << FB, 240 << FB, 800 << FB, 240 << FB, 1, 1);
    add_segment(300 << FB, -100 << FB, 300 << FB, 600 << FB, 1, 1);
    add_segment(-100 << FB, -100 << FB, 800 << FB, 600 << FB, 1, 1);
    add_segment(800 << FB, 600 << FB, -100 << FB, -100 << FB, 1, 1);
    add_segment(-100 << FB, 500 << FB, 800 << FB, 550 << FB, 1, 1);
    add_segment(-100 << FB, 100 << FB, 100 << FB, -100 << FB, 1, 1);
    add_segment(-100 << FB, -100 << FB, 800 << FB, 600 << FB, 0, 1);
    add_segment(CMIN, CMIN, CMAX, CMAX, 1, 1);
    add_segment(CMAX, CMIN, CMIN, CMAX, 1, 1);
    add_segment(50 << FB, 50 << FB, CMAX, CMIN, 1, 1);
    add_segment(-1, 0, 640 << FB, 0, 1, 1);
    add_segment(5, 7, 9, 11, 0, 0);
    add_random(150);
    drain();
    set_window(0, 4095, 0, 4095);
    add_random(150);
    drain();
    set_window(100, 200, 50, 150);
    add_random(150);
    drain();
    set_window(300, 100, 200, 50);
    add_random(100);
    drain();
    set_window(0, 0, 0, 0);
    add_random(100);
    drain();
    set_window(4095, 4095, 4095, 4095);
    add_random(80);
    drain();
    set_window($urandom_range(0, 2000), $urandom_range(2000, 4095),
               $urandom_range(0, 2000), $urandom_range(2000, 4095));
    add_random(100);
    drain();
    idle_on = 0;
    set_window(LEFT_RESET, RIGHT_RESET, BOTTOM_RESET, TOP_RESET);
    add_random(150);
    drain();
    if (errors == 0) begin
      $display("segment_window_clipper_core_tb: clean");
    end else begin
      $display("segment_window_clipper_core_tb: errors");
    end
    $finish;
  end
endmodule
